// ===== design/nrd_pkg.sv =====
// Shared constants for the non-restoring divider pipeline.
package nrd_pkg;

    // Default operand width of the division datapath
    localparam int WIDTH_DEF = 8;

    // Fixed width of the dividend, divisor, quotient and remainder fields
    localparam int FIELD_W = 8;

    // Stream data widths: fields packed from bit 0 up, then padded to whole bytes
    localparam int S_DATA_W = ((2 * FIELD_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((2 * FIELD_W + 1 + 7) / 8) * 8;

endpackage

// ===== design/non_restoring_divider.sv =====
// Top level: unsigned non-restoring divider as a row of step cells.
//
//   channel  direction  handshake            payload
//   s        in         i_s_tvalid/o_s_tready  i_s_tdata: dividend, divisor
//   m        out        o_m_tvalid/i_m_tready  o_m_tdata: quotient, remainder, divide_by_zero
//
// One division step per cell, WIDTH cells, then one correction/output stage;
// a new transfer is taken every cycle while the output is not stalled.
// Each stage holds while its successor is full and stalled, so empty stages
// upstream keep filling while a result waits on the output.
// Reset (i_rst_n low, synchronous) clears all stage valid flags.
module non_restoring_divider #(
    parameter int WIDTH = nrd_pkg::WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [nrd_pkg::S_DATA_W-1:0]  i_s_tdata,   // [7:0] dividend, [15:8] divisor
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [nrd_pkg::M_DATA_W-1:0]  o_m_tdata    // [7:0] quotient, [15:8] remainder,
                                                       // [16] divide_by_zero, rest zero
);

    localparam int FW    = nrd_pkg::FIELD_W;
    localparam int MIN_W = (WIDTH < FW) ? WIDTH : FW;

    logic [FW-1:0]    dividend;
    logic [FW-1:0]    divisor;
    logic [WIDTH-1:0] n_ext;
    logic [WIDTH-1:0] d_ext;

    logic             st_valid [WIDTH+1];
    logic             st_ready [WIDTH+1];
    logic [WIDTH:0]   st_p     [WIDTH+1];
    logic [WIDTH-1:0] st_nq    [WIDTH+1];
    logic [WIDTH-1:0] st_div   [WIDTH+1];

    logic [FW-1:0]    quotient;
    logic [FW-1:0]    remainder;
    logic             divide_by_zero;

    assign dividend = i_s_tdata[FW-1:0];
    assign divisor  = i_s_tdata[2*FW-1:FW];

    always_comb begin
        n_ext = '0;
        d_ext = '0;
        n_ext[MIN_W-1:0] = dividend[MIN_W-1:0];
        d_ext[MIN_W-1:0] = divisor[MIN_W-1:0];
    end

    assign st_valid[0] = i_s_tvalid;
    assign st_p[0]     = '0;
    assign st_nq[0]    = n_ext;
    assign st_div[0]   = d_ext;
    assign o_s_tready  = st_ready[0];

    for (genvar g = 0; g < WIDTH; g++) begin : g_cell
        nrd_cell #(
            .WIDTH (WIDTH)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (st_valid[g]),
            .o_ready (st_ready[g]),
            .i_p     (st_p[g]),
            .i_nq    (st_nq[g]),
            .i_div   (st_div[g]),
            .o_valid (st_valid[g+1]),
            .i_ready (st_ready[g+1]),
            .o_p     (st_p[g+1]),
            .o_nq    (st_nq[g+1]),
            .o_div   (st_div[g+1])
        );
    end

    nrd_fix #(
        .WIDTH (WIDTH)
    ) u_fix (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (st_valid[WIDTH]),
        .o_ready          (st_ready[WIDTH]),
        .i_p              (st_p[WIDTH]),
        .i_nq             (st_nq[WIDTH]),
        .i_div            (st_div[WIDTH]),
        .o_valid          (o_m_tvalid),
        .i_ready          (i_m_tready),
        .o_quotient       (quotient),
        .o_remainder      (remainder),
        .o_divide_by_zero (divide_by_zero)
    );

    always_comb begin
        o_m_tdata = '0;
        o_m_tdata[2*FW:0] = {divide_by_zero, remainder, quotient};
    end

endmodule

// ===== design/nrd_cell.sv =====
// One non-restoring division step, registered, with its own valid/ready.
module nrd_cell #(
    parameter int WIDTH = nrd_pkg::WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [WIDTH:0]   i_p,     // partial remainder, two's complement
    input  logic [WIDTH-1:0] i_nq,    // dividend bits still to use, quotient bits below
    input  logic [WIDTH-1:0] i_div,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [WIDTH:0]   o_p,
    output logic [WIDTH-1:0] o_nq,
    output logic [WIDTH-1:0] o_div
);

    logic             r_valid;
    logic [WIDTH:0]   r_p;
    logic [WIDTH-1:0] r_nq;
    logic [WIDTH-1:0] r_div;

    logic [WIDTH:0]   n_p;
    logic [WIDTH-1:0] n_nq;
    logic [WIDTH:0]   p_shift;
    logic [WIDTH:0]   div_ext;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        // shift in the next dividend bit, MSB first
        p_shift = {i_p[WIDTH-1:0], i_nq[WIDTH-1]};
        div_ext = {1'b0, i_div};
        // add when the old remainder was negative, else subtract
        if (i_p[WIDTH]) begin
            n_p = p_shift + div_ext;
        end else begin
            n_p = p_shift - div_ext;
        end
        n_nq = {i_nq[WIDTH-2:0], ~n_p[WIDTH]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_p   <= n_p;
            r_nq  <= n_nq;
            r_div <= i_div;
        end
    end

    assign o_valid = r_valid;
    assign o_p     = r_p;
    assign o_nq    = r_nq;
    assign o_div   = r_div;

endmodule

// ===== design/nrd_fix.sv =====
// Final remainder correction and the output register of the divider.
module nrd_fix #(
    parameter int WIDTH = nrd_pkg::WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [WIDTH:0]                  i_p,
    input  logic [WIDTH-1:0]                i_nq,
    input  logic [WIDTH-1:0]                i_div,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [nrd_pkg::FIELD_W-1:0]     o_quotient,
    output logic [nrd_pkg::FIELD_W-1:0]     o_remainder,
    output logic                            o_divide_by_zero
);

    localparam int FW    = nrd_pkg::FIELD_W;
    localparam int MIN_W = (WIDTH < FW) ? WIDTH : FW;

    logic          r_valid;
    logic [FW-1:0] r_quot;
    logic [FW-1:0] r_rem;
    logic          r_dz;

    logic [WIDTH-1:0] rem_full;
    logic [FW-1:0]    n_quot;
    logic [FW-1:0]    n_rem;

    assign o_ready = !r_valid || i_ready;

    // A zero divisor needs no special path: every step keeps P non-negative,
    // so the quotient comes out all ones and the remainder equals the dividend.
    always_comb begin
        rem_full = i_p[WIDTH] ? (i_p[WIDTH-1:0] + i_div) : i_p[WIDTH-1:0];
        n_quot = '0;
        n_rem  = '0;
        n_quot[MIN_W-1:0] = i_nq[MIN_W-1:0];
        n_rem[MIN_W-1:0]  = rem_full[MIN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_quot <= n_quot;
            r_rem  <= n_rem;
            r_dz   <= (i_div == '0);
        end
    end

    assign o_valid          = r_valid;
    assign o_quotient       = r_quot;
    assign o_remainder      = r_rem;
    assign o_divide_by_zero = r_dz;

endmodule

// ===== sim/non_restoring_divider_tb.sv =====
// Self-checking stream testbench for the pipelined unsigned non-restoring divider.
`timescale 1ns / 100ps

module non_restoring_divider_tb;

    localparam int WIDTH        = nrd_pkg::WIDTH_DEF;
    localparam int FW           = nrd_pkg::FIELD_W;
    localparam int RANDOM_ITEMS = 750;
    localparam int LONG_HOLD    = 80;
    localparam int HOLD_BURST   = 40;
    localparam int DRAIN_CYCLES = WIDTH + 6;

    typedef struct packed {
        logic [FW-1:0] quotient;
        logic [FW-1:0] remainder;
        logic          div_by_zero;
    } t_div_result;

    typedef struct packed {
        logic [FW-1:0] dividend;
        logic [FW-1:0] divisor;
        logic          typed;     // expectation given in the row itself
        t_div_result   want;
    } t_div_row;

    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_COIN,
        RX_EVERY_THIRD,
        RX_SPARSE
    } t_rx_mode;

    localparam int NUM_ROWS = 24;

    // Extremes, zero divisor and exact/over-range cases carry typed answers;
    // rows marked 0 go through the predictor.
    t_div_row directed_rows [NUM_ROWS] = '{
        '{8'd0,   8'd0,   1'b1, '{8'd255, 8'd0,   1'b1}},
        '{8'd255, 8'd0,   1'b1, '{8'd255, 8'd255, 1'b1}},
        '{8'hA5,  8'd0,   1'b1, '{8'd255, 8'hA5,  1'b1}},
        '{8'd0,   8'd1,   1'b1, '{8'd0,   8'd0,   1'b0}},
        '{8'd255, 8'd1,   1'b1, '{8'd255, 8'd0,   1'b0}},
        '{8'd255, 8'd255, 1'b1, '{8'd1,   8'd0,   1'b0}},
        '{8'd0,   8'd255, 1'b1, '{8'd0,   8'd0,   1'b0}},
        '{8'd1,   8'd255, 1'b1, '{8'd0,   8'd1,   1'b0}},
        '{8'd254, 8'd255, 1'b1, '{8'd0,   8'd254, 1'b0}},
        '{8'd128, 8'd128, 1'b1, '{8'd1,   8'd0,   1'b0}},
        '{8'd127, 8'd128, 1'b1, '{8'd0,   8'd127, 1'b0}},
        '{8'd255, 8'd2,   1'b1, '{8'd127, 8'd1,   1'b0}},
        '{8'd255, 8'd128, 1'b1, '{8'd1,   8'd127, 1'b0}},
        '{8'd128, 8'd1,   1'b1, '{8'd128, 8'd0,   1'b0}},
        '{8'd1,   8'd1,   1'b1, '{8'd1,   8'd0,   1'b0}},
        '{8'd127, 8'd1,   1'b1, '{8'd127, 8'd0,   1'b0}},
        '{8'd200, 8'd7,   1'b0, '0},
        '{8'h55,  8'hAA,  1'b0, '0},
        '{8'hAA,  8'h55,  1'b0, '0},
        '{8'd100, 8'd3,   1'b0, '0},
        '{8'd77,  8'd13,  1'b0, '0},
        '{8'h80,  8'h7F,  1'b0, '0},
        '{8'd250, 8'd16,  1'b0, '0},
        '{8'd13,  8'd200, 1'b0, '0}
    };

    logic                         i_clk      = 1'b0;
    logic                         i_rst_n    = 1'b0;
    logic                         i_s_tvalid = 1'b0;
    logic                         o_s_tready;
    logic [nrd_pkg::S_DATA_W-1:0] i_s_tdata  = '0;    // [7:0] dividend, [15:8] divisor
    logic                         o_m_tvalid;
    logic                         i_m_tready = 1'b0;
    logic [nrd_pkg::M_DATA_W-1:0] o_m_tdata;          // [7:0] quotient, [15:8] remainder,
                                                      // [16] div by zero

    t_div_result pending_divisions [$];
    int          mismatch_count = 0;
    bit          hold_req       = 1'b0;

    non_restoring_divider #(
        .WIDTH (WIDTH)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Partial remainder is WIDTH+1 bits two's complement; quotient bit is the
    // inverted sign after each add/subtract, final negative remainder fixed up.
    function automatic t_div_result nonrestoring_divide(input logic [FW-1:0] dividend,
                                                        input logic [FW-1:0] divisor);
        logic [WIDTH:0]   prem;
        logic [WIDTH-1:0] quo;
        logic             was_neg;
        t_div_result      res;
        res = '0;
        if (divisor[WIDTH-1:0] == '0) begin
            res.quotient    = '1;
            res.remainder   = dividend;
            res.div_by_zero = 1'b1;
        end else begin
            prem = '0;
            quo  = '0;
            for (int i = WIDTH - 1; i >= 0; i--) begin
                was_neg = prem[WIDTH];
                prem    = {prem[WIDTH-1:0], dividend[i]};
                if (was_neg) begin
                    prem = prem + {1'b0, divisor[WIDTH-1:0]};
                end else begin
                    prem = prem - {1'b0, divisor[WIDTH-1:0]};
                end
                quo = {quo[WIDTH-2:0], ~prem[WIDTH]};
            end
            if (prem[WIDTH]) begin
                prem = prem + {1'b0, divisor[WIDTH-1:0]};
            end
            res.quotient  = quo;
            res.remainder = prem[WIDTH-1:0];
        end
        return res;
    endfunction

    // Called right after a rising edge; returns right after the accepting edge.
    task automatic offer_division(input logic [FW-1:0] dividend,
                                  input logic [FW-1:0] divisor,
                                  input t_div_result want);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {divisor, dividend};
        do @(posedge i_clk); while (!o_s_tready);
        pending_divisions.push_back(want);
    endtask

    // Sender: reset, directed table, then random bursts
    initial begin
        logic [FW-1:0] dividend;
        logic [FW-1:0] divisor;
        int            sent;
        int            burst;
        int            gap;
        bit            hold_done;
        bit            drain_done;
        sent       = 0;
        hold_done  = 1'b0;
        drain_done = 1'b0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r]) begin
            offer_division(directed_rows[r].dividend, directed_rows[r].divisor,
                           directed_rows[r].typed ? directed_rows[r].want :
                           nonrestoring_divide(directed_rows[r].dividend,
                                               directed_rows[r].divisor));
        end

        while (sent < RANDOM_ITEMS) begin
            burst = $urandom_range(1, 24);
            if (!hold_done && sent >= 200) begin
                // receiver stalls long; keep offering so the pipe backs up
                hold_done = 1'b1;
                hold_req  = 1'b1;
                burst     = HOLD_BURST;
            end else if (!drain_done && sent >= 450) begin
                drain_done = 1'b1;
                i_s_tvalid <= 1'b0;
                while (pending_divisions.size() != 0) @(posedge i_clk);
            end
            for (int k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
                dividend = FW'($urandom_range(0, 255));
                divisor  = FW'($urandom_range(0, 255));
                case ($urandom_range(0, 9))
                    4: divisor  = '0;
                    5: divisor  = FW'($urandom_range(1, 15));
                    6: divisor  = FW'($urandom_range(dividend, 255));
                    7: divisor  = dividend;
                    8: dividend = $urandom_range(0, 1) ? 8'd255 : 8'd0;
                    9: divisor  = 8'd1 << $urandom_range(0, 7);
                    default: ;
                endcase
                offer_division(dividend, divisor, nonrestoring_divide(dividend, divisor));
                sent++;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_s_tvalid <= 1'b0;

        while (pending_divisions.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Receiver: segments of differing stall patterns, plus one long hold on request
    initial begin
        t_rx_mode mode;
        int       seg_left;
        int       phase;
        bit       hold_taken;
        mode       = RX_ALWAYS;
        seg_left   = 0;
        phase      = 0;
        hold_taken = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                i_m_tready <= 1'b0;
                repeat (LONG_HOLD - 1) @(posedge i_clk);
            end else begin
                if (seg_left == 0) begin
                    mode     = t_rx_mode'($urandom_range(0, 3));
                    seg_left = $urandom_range(10, 60);
                end
                seg_left--;
                phase++;
                case (mode)
                    RX_ALWAYS:      i_m_tready <= 1'b1;
                    RX_COIN:        i_m_tready <= 1'($urandom_range(0, 1));
                    RX_EVERY_THIRD: i_m_tready <= (phase % 3 == 0);
                    RX_SPARSE:      i_m_tready <= ($urandom_range(0, 7) == 0);
                    default:        i_m_tready <= 1'b1;
                endcase
            end
        end
    end

    // Result checker: every output transfer against the oldest expectation
    always @(posedge i_clk) begin
        t_div_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_divisions.size() == 0) begin
                $display("%0t: unexpected result transfer, tdata %h", $realtime, o_m_tdata);
                mismatch_count++;
            end else begin
                want = pending_divisions.pop_front();
                if (o_m_tdata[7:0] !== want.quotient) begin
                    $display("%0t: quotient expected %0d actual %0d",
                             $realtime, want.quotient, o_m_tdata[7:0]);
                    mismatch_count++;
                end
                if (o_m_tdata[15:8] !== want.remainder) begin
                    $display("%0t: remainder expected %0d actual %0d",
                             $realtime, want.remainder, o_m_tdata[15:8]);
                    mismatch_count++;
                end
                if (o_m_tdata[16] !== want.div_by_zero) begin
                    $display("%0t: divide_by_zero expected %0b actual %0b",
                             $realtime, want.div_by_zero, o_m_tdata[16]);
                    mismatch_count++;
                end
                if (o_m_tdata[nrd_pkg::M_DATA_W-1:17] !== '0) begin
                    $display("%0t: tdata padding expected 0 actual %h",
                             $realtime, o_m_tdata[nrd_pkg::M_DATA_W-1:17]);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        #3_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
